// ===== hw/rtl/crt_pkg.sv =====
// Types and constants shared by the chunk reassembly tracker modules.
package crt_pkg;

  localparam logic [1:0] CMD_HDR   = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NO_MAN   = 3'd1;
  localparam logic [2:0] STAT_SESSION  = 3'd2;
  localparam logic [2:0] STAT_FILE     = 3'd3;
  localparam logic [2:0] STAT_INDEX    = 3'd4;
  localparam logic [2:0] STAT_OFFSET   = 3'd5;
  localparam logic [2:0] STAT_SIZE     = 3'd6;
  localparam logic [2:0] STAT_CONFLICT = 3'd7;

  localparam logic [3:0] REG_LOADED      = 4'd0;
  localparam logic [3:0] REG_SESSION_HI  = 4'd1;
  localparam logic [3:0] REG_SESSION_LO  = 4'd2;
  localparam logic [3:0] REG_FILE_HI     = 4'd3;
  localparam logic [3:0] REG_FILE_LO     = 4'd4;
  localparam logic [3:0] REG_CHUNK_BYTES = 4'd5;
  localparam logic [3:0] REG_CHUNK_TOTAL = 4'd6;
  localparam logic [3:0] REG_FILE_BYTES  = 4'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int MAX_RUNS    = 32;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] sess_hi;
    logic [63:0] sess_lo;
    logic [63:0] fid_hi;
    logic [63:0] fid_lo;
    logic [15:0] hdr_total;
    logic [15:0] chunk_idx;
    logic [31:0] chunk_ofs;
    logic [15:0] chunk_length;
    logic [7:0]  data_byte;
  } crt_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       accepted;
    logic       duplicate;
    logic [6:0] received_count;
    logic       all_present;
    logic [5:0] range_start;
    logic [6:0] range_count;
    logic       last;
  } crt_out_t;

  typedef struct packed {
    logic        loaded;
    logic [63:0] session_high;
    logic [63:0] session_low;
    logic [63:0] file_high;
    logic [63:0] file_low;
    logic [8:0]  chunk_bytes;
    logic [6:0]  chunk_total;
    logic [14:0] file_bytes;
  } crt_cfg_t;

  typedef enum logic [1:0] {
    OP_FAIL  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_BYTE  = 2'd2,
    OP_QUERY = 2'd3
  } crt_kind_t;

  typedef struct packed {
    crt_kind_t   kind;
    logic [2:0]  status;
    logic [15:0] idx;
    logic [15:0] len;
    logic [7:0]  data;
  } crt_op_t;

endpackage

// ===== hw/rtl/crt_ram.sv =====
// Generic single-port RAM with registered read.
module crt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/crt_front.sv =====
// Front end: accepts items, checks headers and queues operations.
module crt_front #(
  parameter int MAX_CHUNKS = 64,
  parameter int MAX_CHUNK_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  crt_pkg::crt_cfg_t cfg,
  input  logic              push,
  input  crt_pkg::crt_in_t  item,
  output logic              full,
  output logic              op_valid,
  output crt_pkg::crt_op_t  op,
  input  logic              op_pop
);
  import crt_pkg::*;

  logic [24:0]         consumed;
  logic [16:0]         idx_p1;
  logic [31:0]         want;
  logic [2:0]          hdr_status;
  crt_op_t             op_in;
  logic                wr;
  crt_op_t             q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp, rp;
  logic [QUEUE_AW:0]   cnt;

  assign consumed = 25'(item.chunk_idx) * 25'(cfg.chunk_bytes);
  assign idx_p1   = 17'(item.chunk_idx) + 17'd1;

  always_comb begin
    if (idx_p1 < 17'(cfg.chunk_total)) begin
      want = 32'(cfg.chunk_bytes);
    end else begin
      want = 32'(cfg.file_bytes) - 32'(consumed);
    end
  end

  always_comb begin
    priority if (!cfg.loaded) begin
      hdr_status = STAT_NO_MAN;
    end else if (item.sess_hi != cfg.session_high || item.sess_lo != cfg.session_low) begin
      hdr_status = STAT_SESSION;
    end else if (item.fid_hi != cfg.file_high || item.fid_lo != cfg.file_low) begin
      hdr_status = STAT_FILE;
    end else if (item.hdr_total != 16'(cfg.chunk_total)
                 || 17'(item.chunk_idx) >= 17'(cfg.chunk_total)
                 || 17'(item.chunk_idx) >= 17'(MAX_CHUNKS)) begin
      hdr_status = STAT_INDEX;
    end else if (item.chunk_ofs != 32'(consumed)) begin
      hdr_status = STAT_OFFSET;
    end else if (32'(item.chunk_length) != want
                 || 17'(item.chunk_length) > 17'(MAX_CHUNK_BYTES)) begin
      hdr_status = STAT_SIZE;
    end else begin
      hdr_status = STAT_OK;
    end
  end

  always_comb begin
    op_in.status = hdr_status;
    op_in.idx    = item.chunk_idx;
    op_in.len    = item.chunk_length;
    op_in.data   = item.data_byte;
    unique case (item.cmd)
      CMD_HDR:   op_in.kind = (hdr_status == STAT_OK) ? OP_OPEN : OP_FAIL;
      CMD_BYTE:  op_in.kind = OP_BYTE;
      CMD_QUERY: op_in.kind = OP_QUERY;
      default:   op_in.kind = OP_QUERY;
    endcase
  end

  assign full     = (cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign op_valid = (cnt != '0);
  assign op       = q[rp];
  assign wr       = push && !full && (item.cmd != CMD_NONE);

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= op_in;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (op_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QUEUE_AW+1)'(wr) - (QUEUE_AW+1)'(op_pop);
    end
  end

endmodule

// ===== hw/rtl/crt_back.sv =====
// Back end: runs operations against the presence map and chunk store, queues results.
module crt_back #(
  parameter int MAX_CHUNKS = 64,
  parameter int MAX_CHUNK_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  crt_pkg::crt_cfg_t cfg,
  input  logic              clear,
  input  logic              op_valid,
  input  crt_pkg::crt_op_t  op,
  output logic              op_pop,
  output logic              empty,
  input  logic              pop,
  output crt_pkg::crt_out_t result
);
  import crt_pkg::*;

  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int BW = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
  localparam int LW = $clog2(MAX_CHUNK_BYTES + 1);
  localparam int DEPTH = MAX_CHUNKS * MAX_CHUNK_BYTES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [MAX_CHUNKS-1:0] presence, presence_next;
  logic [6:0]      held_count, held_count_next;
  logic            open_chunk, open_chunk_next;
  logic [CW-1:0]   open_index, open_index_next;
  logic [LW-1:0]   bytes_left, bytes_left_next;
  logic [BW-1:0]   byte_position, byte_position_next;
  logic            is_repeat, is_repeat_next;
  logic            content_differs, content_differs_next;
  logic            s2_cmp, s2_cmp_next;
  logic            s2_fin, s2_fin_next;
  logic [7:0]      s2_byte, s2_byte_next;
  logic [CW:0]     wi, wi_next;
  logic [5:0]      wk, wk_next;
  logic            in_run, in_run_next;
  logic [CW:0]     run_start, run_start_next;
  logic            pend_valid, pend_valid_next;
  logic [CW:0]     pend_start, pend_start_next;
  logic [CW:0]     pend_cnt, pend_cnt_next;

  logic            go;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_rdata;
  logic            diff_now;
  logic [CW:0]     walk_n;
  logic [6:0]      cnt_inc;

  logic            res_push;
  crt_out_t        res_in;
  crt_out_t        oq [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] owp, orp;
  logic [QUEUE_AW:0]   ocnt;
  logic            out_full;
  logic            out_pop;

  crt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (op.data),
    .rdata (ram_rdata)
  );

  function automatic crt_out_t mk(input logic [2:0] st, input logic acc, input logic dup,
                                  input logic [5:0] rs, input logic [6:0] rc,
                                  input logic lst, input logic [6:0] cnt,
                                  input logic [6:0] total, input logic loaded);
    crt_out_t r;
    r.status         = st;
    r.accepted       = acc;
    r.duplicate      = dup;
    r.received_count = cnt;
    r.all_present    = loaded && (cnt == total);
    r.range_start    = rs;
    r.range_count    = rc;
    r.last           = lst;
    return r;
  endfunction

  assign out_full = (ocnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (ocnt == '0);
  assign result   = oq[orp];
  assign out_pop  = pop && !empty;
  assign cnt_inc  = held_count + 7'd1;
  assign diff_now = content_differs || (s2_cmp && (ram_rdata != s2_byte));
  assign go       = (state == S_RUN) && op_valid && !s2_fin && !out_full;
  assign op_pop   = go;
  assign ram_addr = AW'(open_index) * AW'(MAX_CHUNK_BYTES) + AW'(byte_position);

  always_comb begin
    if (32'(cfg.chunk_total) < 32'(MAX_CHUNKS)) begin
      walk_n = (CW+1)'(cfg.chunk_total);
    end else begin
      walk_n = (CW+1)'(MAX_CHUNKS);
    end
  end

  always_comb begin
    state_next           = state;
    presence_next        = presence;
    held_count_next      = held_count;
    open_chunk_next      = open_chunk;
    open_index_next      = open_index;
    bytes_left_next      = bytes_left;
    byte_position_next   = byte_position;
    is_repeat_next       = is_repeat;
    content_differs_next = content_differs;
    s2_cmp_next          = 1'b0;
    s2_fin_next          = 1'b0;
    s2_byte_next         = s2_byte;
    wi_next              = wi;
    wk_next              = wk;
    in_run_next          = in_run;
    run_start_next       = run_start;
    pend_valid_next      = pend_valid;
    pend_start_next      = pend_start;
    pend_cnt_next        = pend_cnt;
    ram_we               = 1'b0;
    res_push             = 1'b0;
    res_in               = mk(STAT_OK, 1'b0, 1'b0, 6'd0, 7'd0, 1'b1, held_count,
                              cfg.chunk_total, cfg.loaded);

    // finish a chunk whose last byte went through the store last cycle
    if (s2_cmp || s2_fin) begin
      content_differs_next = diff_now;
    end
    if (s2_fin) begin
      res_push = 1'b1;
      if (is_repeat) begin
        res_in = diff_now
               ? mk(STAT_CONFLICT, 1'b0, 1'b0, 6'd0, 7'd0, 1'b1, held_count,
                    cfg.chunk_total, cfg.loaded)
               : mk(STAT_OK, 1'b1, 1'b1, 6'd0, 7'd0, 1'b1, held_count,
                    cfg.chunk_total, cfg.loaded);
      end else begin
        presence_next[open_index] = 1'b1;
        held_count_next = cnt_inc;
        res_in = mk(STAT_OK, 1'b1, 1'b0, 6'd0, 7'd0, 1'b1, cnt_inc,
                    cfg.chunk_total, cfg.loaded);
      end
    end

    unique case (state)
      S_RUN: begin
        if (go) begin
          unique case (op.kind)
            OP_FAIL: begin
              open_chunk_next = 1'b0;
              res_push = 1'b1;
              res_in = mk(op.status, 1'b0, 1'b0, 6'd0, 7'd0, 1'b1, held_count,
                          cfg.chunk_total, cfg.loaded);
            end
            OP_OPEN: begin
              open_index_next      = CW'(op.idx);
              bytes_left_next      = LW'(op.len);
              byte_position_next   = '0;
              is_repeat_next       = presence[CW'(op.idx)];
              content_differs_next = 1'b0;
              if (op.len == 16'd0) begin
                open_chunk_next = 1'b0;
                res_push = 1'b1;
                if (presence[CW'(op.idx)]) begin
                  res_in = mk(STAT_OK, 1'b1, 1'b1, 6'd0, 7'd0, 1'b1, held_count,
                              cfg.chunk_total, cfg.loaded);
                end else begin
                  presence_next[CW'(op.idx)] = 1'b1;
                  held_count_next = cnt_inc;
                  res_in = mk(STAT_OK, 1'b1, 1'b0, 6'd0, 7'd0, 1'b1, cnt_inc,
                              cfg.chunk_total, cfg.loaded);
                end
              end else begin
                open_chunk_next = 1'b1;
              end
            end
            OP_BYTE: begin
              if (open_chunk) begin
                ram_we             = !is_repeat;
                s2_cmp_next        = is_repeat;
                s2_byte_next       = op.data;
                byte_position_next = byte_position + 1'b1;
                bytes_left_next    = bytes_left - 1'b1;
                if (bytes_left == LW'(1)) begin
                  s2_fin_next     = 1'b1;
                  open_chunk_next = 1'b0;
                end
              end
            end
            OP_QUERY: begin
              if (!cfg.loaded) begin
                res_push = 1'b1;
                res_in = mk(STAT_NO_MAN, 1'b0, 1'b0, 6'd0, 7'd0, 1'b1, held_count,
                            cfg.chunk_total, cfg.loaded);
              end else begin
                state_next      = S_WALK;
                wi_next         = '0;
                wk_next         = '0;
                in_run_next     = 1'b0;
                pend_valid_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (!out_full) begin
          if (wi < walk_n) begin
            wi_next = wi + 1'b1;
            if (!in_run && !presence[wi[CW-1:0]]) begin
              in_run_next    = 1'b1;
              run_start_next = wi;
            end else if (in_run && presence[wi[CW-1:0]]) begin
              in_run_next     = 1'b0;
              res_push        = pend_valid;
              res_in = mk(STAT_OK, 1'b0, 1'b0, 6'(pend_start), 7'(pend_cnt), 1'b0,
                          held_count, cfg.chunk_total, cfg.loaded);
              pend_valid_next = 1'b1;
              pend_start_next = run_start;
              pend_cnt_next   = wi - run_start;
              wk_next         = wk + 6'd1;
              if (wk == 6'(MAX_RUNS - 1)) begin
                state_next = S_FLUSH;
              end
            end
          end else begin
            state_next = S_FLUSH;
            if (in_run) begin
              in_run_next     = 1'b0;
              res_push        = pend_valid;
              res_in = mk(STAT_OK, 1'b0, 1'b0, 6'(pend_start), 7'(pend_cnt), 1'b0,
                          held_count, cfg.chunk_total, cfg.loaded);
              pend_valid_next = 1'b1;
              pend_start_next = run_start;
              pend_cnt_next   = wi - run_start;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!out_full) begin
          res_push   = 1'b1;
          state_next = S_RUN;
          if (pend_valid) begin
            res_in = mk(STAT_OK, 1'b0, 1'b0, 6'(pend_start), 7'(pend_cnt), 1'b1,
                        held_count, cfg.chunk_total, cfg.loaded);
          end else begin
            res_in = mk(STAT_OK, 1'b0, 1'b0, 6'd0, 7'd0, 1'b1, held_count,
                        cfg.chunk_total, cfg.loaded);
          end
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    s2_byte    <= s2_byte_next;
    run_start  <= run_start_next;
    pend_start <= pend_start_next;
    pend_cnt   <= pend_cnt_next;
    wk         <= wk_next;
    wi         <= wi_next;
    if (res_push) begin
      oq[owp] <= res_in;
    end
    if (rst || clear) begin
      state           <= S_RUN;
      presence        <= '0;
      held_count      <= '0;
      open_chunk      <= 1'b0;
      open_index      <= '0;
      bytes_left      <= '0;
      byte_position   <= '0;
      is_repeat       <= 1'b0;
      content_differs <= 1'b0;
      s2_cmp          <= 1'b0;
      s2_fin          <= 1'b0;
      in_run          <= 1'b0;
      pend_valid      <= 1'b0;
    end else begin
      state           <= state_next;
      presence        <= presence_next;
      held_count      <= held_count_next;
      open_chunk      <= open_chunk_next;
      open_index      <= open_index_next;
      bytes_left      <= bytes_left_next;
      byte_position   <= byte_position_next;
      is_repeat       <= is_repeat_next;
      content_differs <= content_differs_next;
      s2_cmp          <= s2_cmp_next;
      s2_fin          <= s2_fin_next;
      in_run          <= in_run_next;
      pend_valid      <= pend_valid_next;
    end
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (res_push) begin
        owp <= owp + 1'b1;
      end
      if (out_pop) begin
        orp <= orp + 1'b1;
      end
      ocnt <= ocnt + (QUEUE_AW+1)'(res_push) - (QUEUE_AW+1)'(out_pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full || out_pop)
    else $error("result pushed into full queue");
  a_fin_stalls: assert property (@(posedge clk) disable iff (rst)
    s2_fin |-> !op_pop)
    else $error("operation taken while a chunk finishes");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (wi <= walk_n) && (wk < 6'(MAX_RUNS)))
    else $error("walk past its bound");
  a_fin_follows_byte: assert property (@(posedge clk) disable iff (rst || clear)
    s2_fin |-> $past(op_pop) && !open_chunk)
    else $error("finish without a final byte");
`endif

endmodule

// ===== hw/rtl/chunk_reassembly_tracker_core.sv =====
// Top level of the chunk reassembly tracker: configuration registers, front and back ends.
// Headers, payload bytes and queries are taken at one per cycle, unless the four-entry operation
// queue is full; the back end runs one payload byte per cycle while no chunk is finishing and
// the result queue is not full, and stalls at the end of each chunk while the store compare
// settles and presence is updated. A query walks the presence map one chunk per cycle while
// the four-entry result queue is not full, over at most min(chunk_total, MAX_CHUNKS) chunks
// and MAX_RUNS runs. A write to any of the eight registers clears presence, the held count
// and an open chunk.
module chunk_reassembly_tracker_core #(
  parameter int MAX_CHUNKS = 64,
  parameter int MAX_CHUNK_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              push,
  input  crt_pkg::crt_in_t  item,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output crt_pkg::crt_out_t result
);
  import crt_pkg::*;

  crt_cfg_t cfg;
  logic     cfg_clear;
  logic     op_valid;
  logic     op_pop;
  crt_op_t  op;

  assign cfg_clear = cfg_we && !cfg_index[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loaded       <= 1'b0;
      cfg.session_high <= '0;
      cfg.session_low  <= '0;
      cfg.file_high    <= '0;
      cfg.file_low     <= '0;
      cfg.chunk_bytes  <= 9'd256;
      cfg.chunk_total  <= '0;
      cfg.file_bytes   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOADED:      cfg.loaded       <= cfg_data[0];
        REG_SESSION_HI:  cfg.session_high <= cfg_data;
        REG_SESSION_LO:  cfg.session_low  <= cfg_data;
        REG_FILE_HI:     cfg.file_high    <= cfg_data;
        REG_FILE_LO:     cfg.file_low     <= cfg_data;
        REG_CHUNK_BYTES: cfg.chunk_bytes  <= cfg_data[8:0];
        REG_CHUNK_TOTAL: cfg.chunk_total  <= cfg_data[6:0];
        REG_FILE_BYTES:  cfg.file_bytes   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  crt_front #(.MAX_CHUNKS(MAX_CHUNKS), .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst || cfg_clear),
    .cfg      (cfg),
    .push     (push),
    .item     (item),
    .full     (full),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  crt_back #(.MAX_CHUNKS(MAX_CHUNKS), .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clear    (cfg_clear),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== dv/crt_scoreboard.sv =====
// Checker for the chunk reassembly tracker: models the block and compares every result.
module crt_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              push,
  input  crt_pkg::crt_in_t  item,
  input  logic              full,
  input  logic              empty,
  input  logic              pop,
  input  crt_pkg::crt_out_t result,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  localparam int NCH = 64;
  localparam int NBY = 256;

  crt_cfg_t manifest;
  logic [NCH-1:0] present;
  logic [6:0] held;
  logic [7:0] store [NCH*NBY];
  logic chunk_open, repeat_chunk, differs;
  logic [5:0] open_idx;
  logic [8:0] left;
  logic [7:0] pos;
  crt_out_t expected_results[$];

  task automatic report(input string what, input crt_out_t got, input crt_out_t want);
    fail_count++;
    $display("mismatch %s: got %p want %p at %0t", what, got, want, $time);
  endtask

  task automatic expect_result(input crt_out_t r);
    expected_results = {expected_results, r};
  endtask

  function automatic crt_out_t make_result(logic [2:0] st, logic acc, logic dup,
                                           logic [5:0] rs, logic [6:0] rc, logic lst);
    crt_out_t r;
    r.status = st; r.accepted = acc; r.duplicate = dup;
    r.received_count = held;
    r.all_present = manifest.loaded && (held == manifest.chunk_total);
    r.range_start = rs; r.range_count = rc; r.last = lst;
    return r;
  endfunction

  task automatic clear_progress();
    present = '0; held = '0; chunk_open = 0; open_idx = '0; left = '0; pos = '0;
    repeat_chunk = 0; differs = 0;
  endtask

  task automatic close_chunk();
    chunk_open = 0;
    if (repeat_chunk) begin
      if (differs) expect_result(make_result(STAT_CONFLICT, 0, 0, 0, 0, 1));
      else expect_result(make_result(STAT_OK, 1, 1, 0, 0, 1));
    end else begin
      present[open_idx] = 1;
      held = held + 7'd1;
      expect_result(make_result(STAT_OK, 1, 0, 0, 0, 1));
    end
  endtask

  task automatic predict_header(crt_in_t h);
    logic [31:0] consumed, want;
    consumed = 32'(h.chunk_idx) * 32'(manifest.chunk_bytes);
    chunk_open = 0;
    if (!manifest.loaded)
      expect_result(make_result(STAT_NO_MAN, 0, 0, 0, 0, 1));
    else if (h.sess_hi != manifest.session_high || h.sess_lo != manifest.session_low)
      expect_result(make_result(STAT_SESSION, 0, 0, 0, 0, 1));
    else if (h.fid_hi != manifest.file_high || h.fid_lo != manifest.file_low)
      expect_result(make_result(STAT_FILE, 0, 0, 0, 0, 1));
    else if (h.hdr_total != 16'(manifest.chunk_total) ||
             h.chunk_idx >= 16'(manifest.chunk_total) || h.chunk_idx >= NCH)
      expect_result(make_result(STAT_INDEX, 0, 0, 0, 0, 1));
    else if (h.chunk_ofs != consumed)
      expect_result(make_result(STAT_OFFSET, 0, 0, 0, 0, 1));
    else begin
      if (32'(h.chunk_idx) + 1 < 32'(manifest.chunk_total)) want = 32'(manifest.chunk_bytes);
      else want = 32'(manifest.file_bytes) - consumed;
      if (32'(h.chunk_length) != want || h.chunk_length > NBY)
        expect_result(make_result(STAT_SIZE, 0, 0, 0, 0, 1));
      else begin
        chunk_open = 1; open_idx = h.chunk_idx[5:0]; left = h.chunk_length[8:0];
        pos = '0; repeat_chunk = present[h.chunk_idx[5:0]]; differs = 0;
        if (h.chunk_length == 0) close_chunk();
      end
    end
  endtask

  task automatic predict_byte(logic [7:0] b);
    int addr;
    if (!chunk_open) return;
    addr = int'(open_idx) * NBY + int'(pos);
    if (repeat_chunk) begin
      if (store[addr] !== b) differs = 1;
    end else store[addr] = b;
    pos++;
    left--;
    if (left == 0) close_chunk();
  endtask

  task automatic predict_query();
    int n, i, k, start;
    crt_out_t r;
    n = (manifest.chunk_total < NCH) ? manifest.chunk_total : NCH;
    i = 0; k = 0;
    if (!manifest.loaded) begin
      expect_result(make_result(STAT_NO_MAN, 0, 0, 0, 0, 1));
      return;
    end
    while (i < n && k < MAX_RUNS) begin
      while (i < n && present[i]) i++;
      if (i >= n) break;
      start = i;
      while (i < n && !present[i]) i++;
      expect_result(make_result(STAT_OK, 0, 0, 6'(start), 7'(i - start), 0));
      k++;
    end
    if (k == 0) expect_result(make_result(STAT_OK, 0, 0, 0, 0, 1));
    else begin
      r = expected_results.pop_back();
      r.last = 1;
      expect_result(r);
    end
  endtask

  always @(posedge clk) begin
    crt_out_t want;
    if (rst) begin
      manifest = '0;
      manifest.chunk_bytes = 9'd256;
      clear_progress();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (!empty && pop) begin
        if (expected_results.size() == 0) begin
          report("unexpected", result, '0);
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status) report("status", result, want);
          if (result.accepted !== want.accepted) report("accepted", result, want);
          if (result.duplicate !== want.duplicate) report("duplicate", result, want);
          if (result.received_count !== want.received_count) report("count", result, want);
          if (result.all_present !== want.all_present) report("all_present", result, want);
          if (result.range_start !== want.range_start) report("range_start", result, want);
          if (result.range_count !== want.range_count) report("range_count", result, want);
          if (result.last !== want.last) report("last", result, want);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LOADED:      manifest.loaded = cfg_data[0];
          REG_SESSION_HI:  manifest.session_high = cfg_data;
          REG_SESSION_LO:  manifest.session_low = cfg_data;
          REG_FILE_HI:     manifest.file_high = cfg_data;
          REG_FILE_LO:     manifest.file_low = cfg_data;
          REG_CHUNK_BYTES: manifest.chunk_bytes = cfg_data[8:0];
          REG_CHUNK_TOTAL: manifest.chunk_total = cfg_data[6:0];
          REG_FILE_BYTES:  manifest.file_bytes = cfg_data[14:0];
          default: ;
        endcase
        if (cfg_index <= REG_FILE_BYTES) clear_progress();
      end
      if (push && !full) begin
        case (item.cmd)
          CMD_HDR:   predict_header(item);
          CMD_BYTE:  predict_byte(item.data_byte);
          CMD_QUERY: predict_query();
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end
endmodule

// ===== dv/tb_chunk_reassembly_tracker_core.sv =====
// Testbench top for the chunk reassembly tracker: stimulus, handshakes and verdict.
module tb_chunk_reassembly_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [3:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic push = 0, pop = 0;
  crt_in_t item = '0;
  logic full, empty;
  crt_out_t result;
  int fail_count, pending;
  int hold_off = 0;
  int items_sent = 0;

  crt_cfg_t plan;

  always #6 clk = ~clk;

  chunk_reassembly_tracker_core DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .push, .item, .full, .empty, .pop, .result
  );

  crt_scoreboard checker_i (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .push, .item, .full,
    .empty, .pop, .result, .fail_count, .pending
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // receiver: random pops, with a long hold-off when requested
  always @(negedge clk) begin
    if (rst) pop <= 0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 0;
    end else pop <= ($urandom_range(0, 99) < 70);
  end

  // returns at the accepting edge with push high; a next-call gap or drain drops it
  task automatic send(crt_in_t it);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      push <= 0;
      repeat (g) @(negedge clk);
    end
    item <= it;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_manifest(crt_cfg_t m);
    write_reg(REG_SESSION_HI, m.session_high);
    write_reg(REG_SESSION_LO, m.session_low);
    write_reg(REG_FILE_HI, m.file_high);
    write_reg(REG_FILE_LO, m.file_low);
    write_reg(REG_CHUNK_BYTES, 64'(m.chunk_bytes));
    write_reg(REG_CHUNK_TOTAL, 64'(m.chunk_total));
    write_reg(REG_FILE_BYTES, 64'(m.file_bytes));
    write_reg(REG_LOADED, 64'(m.loaded));
  endtask

  function automatic crt_in_t good_header(int idx);
    crt_in_t h;
    int len;
    h = '0;
    h.cmd = CMD_HDR;
    h.sess_hi = plan.session_high; h.sess_lo = plan.session_low;
    h.fid_hi = plan.file_high; h.fid_lo = plan.file_low;
    h.hdr_total = 16'(plan.chunk_total);
    h.chunk_idx = 16'(idx);
    h.chunk_ofs = 32'(idx) * 32'(plan.chunk_bytes);
    if (idx + 1 < plan.chunk_total) len = plan.chunk_bytes;
    else len = int'(plan.file_bytes) - idx * int'(plan.chunk_bytes);
    h.chunk_length = 16'(len);
    h.data_byte = 8'($urandom());
    return h;
  endfunction

  function automatic crt_in_t with_cmd(logic [1:0] c);
    crt_in_t it;
    it = '0;
    it.cmd = c;
    it.data_byte = 8'($urandom());
    return it;
  endfunction

  // content per chunk, so repeats usually match
  logic [7:0] content_seed [64];

  task automatic send_chunk(int idx, bit corrupt, int cut);
    crt_in_t h, b;
    int n;
    h = good_header(idx);
    send(h);
    n = h.chunk_length;
    if (n > 256) return;
    if (cut >= 0 && cut < n) n = cut;
    for (int j = 0; j < n; j++) begin
      b = with_cmd(CMD_BYTE);
      b.data_byte = content_seed[idx] + 8'(j * 7);
      if (corrupt && j == n - 1) b.data_byte = ~b.data_byte;
      send(b);
    end
  endtask

  task automatic send_noise();
    crt_in_t it;
    logic [351:0] raw;
    raw = {$urandom(), rand64(), rand64(), rand64(), rand64(), rand64()};
    it = raw[$bits(crt_in_t)-1:0];
    if ($urandom_range(0, 1)) it.cmd = CMD_HDR;
    send(it);
  endtask

  task automatic random_plan(int sz);
    plan.loaded = 1;
    plan.session_high = rand64(); plan.session_low = rand64();
    plan.file_high = rand64(); plan.file_low = rand64();
    plan.chunk_bytes = 9'($urandom_range(1, sz));
    plan.chunk_total = 7'($urandom_range(1, 12));
    plan.file_bytes = 15'((plan.chunk_total - 1) * plan.chunk_bytes
                          + $urandom_range(0, plan.chunk_bytes));
    for (int i = 0; i < 64; i++) content_seed[i] = 8'($urandom());
  endtask

  initial begin
    int phase;
    crt_in_t h;
    int idx;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: no manifest
    send(good_header(0));
    send(with_cmd(CMD_QUERY));
    send(with_cmd(CMD_BYTE));
    send(with_cmd(CMD_NONE));
    drain();

    // directed: extremes of identifiers and sizes, each header failure
    plan = '0;
    plan.loaded = 1;
    plan.session_high = '1; plan.session_low = '0;
    plan.file_high = '0; plan.file_low = '1;
    plan.chunk_bytes = 9'd256; plan.chunk_total = 7'd64;
    plan.file_bytes = 15'(63 * 256 + 5);
    for (int i = 0; i < 64; i++) content_seed[i] = 8'($urandom());
    load_manifest(plan);
    send(with_cmd(CMD_QUERY));
    h = good_header(1); h.sess_hi = '0; send(h);
    h = good_header(1); h.fid_lo = '0; send(h);
    h = good_header(1); h.hdr_total = '1; send(h);
    h = good_header(64); h.hdr_total = 16'd64; send(h);
    h = good_header(1); h.chunk_ofs = '1; send(h);
    h = good_header(1); h.chunk_length = '1; send(h);
    send_chunk(63, 0, -1);
    send_chunk(63, 0, -1);
    send_chunk(63, 1, -1);
    send_chunk(5, 0, 3);
    send_chunk(0, 0, 3);
    send(with_cmd(CMD_QUERY));
    drain();

    // directed: many runs, empty last chunk, small chunk size
    plan.chunk_bytes = 9'd1; plan.chunk_total = 7'd64; plan.file_bytes = 15'd63;
    load_manifest(plan);
    for (int i = 0; i < 64; i += 2) send_chunk(i, 0, -1);
    send(with_cmd(CMD_QUERY));
    send_chunk(63, 0, -1);
    send(with_cmd(CMD_QUERY));
    drain();
    plan.chunk_total = 7'd0; plan.file_bytes = 15'd0;
    write_reg(REG_CHUNK_TOTAL, 64'd0);
    send(with_cmd(CMD_QUERY));
    drain();
    write_reg(REG_LOADED, 64'd0);
    plan.loaded = 0;
    send(with_cmd(CMD_QUERY));
    drain();

    // random phases
    phase = 0;
    while (items_sent < 380) begin
      random_plan(($urandom_range(0, 9) == 0) ? 40 : 12);
      load_manifest(plan);
      if (phase == 0 || $urandom_range(0, 2) == 0) hold_off = $urandom_range(200, 400);
      for (int k = 0; k < 14 && items_sent < 380; k++) begin
        idx = $urandom_range(0, plan.chunk_total - 1);
        case ($urandom_range(0, 9))
          0: send_noise();
          1: send_chunk(idx, 1, -1);
          2: send_chunk(idx, 0, $urandom_range(0, 3));
          3: send(with_cmd(CMD_QUERY));
          default: send_chunk(idx, 0, -1);
        endcase
      end
      send(with_cmd(CMD_QUERY));
      drain();
      phase++;
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
